### hw/rtl/nots_pkg.sv
// Shared types and constants for the nearest-of-three server dispatcher.
`default_nettype none

package nots_pkg;

   // Field widths fixed by the stream and register formats.
   localparam int FIELD_W   = 12;
   localparam int CHOSEN_W  = 2;
   localparam int MOVED_W   = 21;
   localparam int TOTAL_W   = 32;
   localparam int REQ_DW    = 24;
   localparam int RSP_DW    = 56;
   localparam int CSR_IW    = 3;

   localparam int NUM_SERVERS = 3;
   localparam int CSR_COUNT   = 6;

   // Register indexes of the start positions.
   localparam logic [CSR_IW-1:0] CSR_START0_X = 3'd0;
   localparam logic [CSR_IW-1:0] CSR_START0_Y = 3'd1;
   localparam logic [CSR_IW-1:0] CSR_START1_X = 3'd2;
   localparam logic [CSR_IW-1:0] CSR_START1_Y = 3'd3;
   localparam logic [CSR_IW-1:0] CSR_START2_X = 3'd4;
   localparam logic [CSR_IW-1:0] CSR_START2_Y = 3'd5;
   localparam logic [CSR_IW-1:0] CSR_LIMIT    = 3'd6;

   // Reset values of the start registers, in index order.
   localparam logic [FIELD_W-1:0] CFG_RESET [CSR_COUNT] =
      '{12'd1, 12'd1, 12'd1592, 12'd1, 12'd787, 12'd936};

   // Chosen code that acknowledges a restart.
   localparam logic [CHOSEN_W-1:0] CHOSEN_RESTART = 2'd3;
   localparam logic [CHOSEN_W-1:0] SERVER_0       = 2'd0;
   localparam logic [CHOSEN_W-1:0] SERVER_1       = 2'd1;
   localparam logic [CHOSEN_W-1:0] SERVER_2       = 2'd2;

   // Sequencer states.
   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_MUL  = 4'b0010,
      ST_SQRT = 4'b0100,
      ST_EMIT = 4'b1000
   } state_type;

endpackage

`default_nettype wire

### hw/rtl/nearest_of_three_server_dispatch.sv
// Greedy nearest-of-three server dispatcher with one shared squarer and a bitwise square root.
//
//   Channel   Direction  Handshake               Payload
//   req_      in         req_tvalid/req_tready   tdata: point_x, point_y; tuser: restart
//   rsp_      out        rsp_tvalid/rsp_tready   tdata: chosen, moved, running_total
//   csr_      in         csr_valid/csr_ready     csr_index, csr_data
//
// A request passes the squarer state, which forms the six squared differences, then the
// root state, which computes COORD_BITS + 9 root bits, then the post state; requests are
// taken only in idle, so the block takes no new request before the last one is posted;
// a restart goes from idle straight to the post state. Reset is synchronous and restores the
// start registers, the positions and the total. A finished result waits in the output
// register while a new request is taken; the next result holds the block until it frees.
`default_nettype none

module nearest_of_three_server_dispatch #(
   parameter int COORD_BITS = 12
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [23:0]  req_tdata,   // point_x [11:0], point_y [23:12]
   input  wire logic         req_tuser,   // restart [0]
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [55:0]       rsp_tdata,   // chosen [1:0], moved [22:2], running_total [54:23], zero [55]
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [2:0]   csr_index,
   input  wire logic [11:0]  csr_data
);
   import nots_pkg::*;

   localparam int CW    = COORD_BITS;
   localparam int PW    = 2 * COORD_BITS;
   localparam int D2W   = 2 * COORD_BITS + 1;
   localparam int SQ_R  = COORD_BITS + 9;
   localparam int SQ_VW = 2 * SQ_R;
   localparam int SQ_CW = $clog2(SQ_R);
   localparam logic [2:0] MUL_LAST = 3'd7;

   // Registers and their next values.
   state_type             state_ff, state_in;
   logic [FIELD_W-1:0]    cfg_ff [CSR_COUNT];
   logic [FIELD_W-1:0]    cfg_in [CSR_COUNT];
   logic [CW-1:0]         pos_x_ff [NUM_SERVERS];
   logic [CW-1:0]         pos_x_in [NUM_SERVERS];
   logic [CW-1:0]         pos_y_ff [NUM_SERVERS];
   logic [CW-1:0]         pos_y_in [NUM_SERVERS];
   logic [TOTAL_W-1:0]    total_ff, total_in;
   logic [2:0]            cnt_ff, cnt_in;
   logic [CW-1:0]         px_ff, px_in, py_ff, py_in;
   logic [PW-1:0]         prod_ff, prod_in;
   logic [D2W-1:0]        acc_ff, acc_in, best_d_ff, best_d_in;
   logic [CHOSEN_W-1:0]   best_ff, best_in;
   logic [SQ_R+1:0]       rem_ff, rem_in;
   logic [SQ_R-1:0]       root_ff, root_in;
   logic [SQ_VW-1:0]      rad_ff, rad_in;
   logic [SQ_CW-1:0]      sq_cnt_ff, sq_cnt_in;
   logic [MOVED_W-1:0]    moved_ff, moved_in;
   logic                  restart_ff, restart_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [CHOSEN_W-1:0]   rsp_chosen_ff, rsp_chosen_in;
   logic [MOVED_W-1:0]    rsp_moved_ff, rsp_moved_in;
   logic [TOTAL_W-1:0]    rsp_total_ff, rsp_total_in;

   // Combinational helpers.
   logic [1:0]            mul_srv, prev_srv;
   logic [2:0]            prev;
   logic [CW-1:0]         mul_pos, mul_pt, mul_diff;
   logic [PW-1:0]         mul_prod;
   logic [D2W-1:0]        dist_sum;
   logic [SQ_R+1:0]       rem_sh, trial;
   logic [TOTAL_W:0]      tot_sum;
   logic [TOTAL_W-1:0]    total_sat;
   logic                  out_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_total_ff, rsp_moved_ff, rsp_chosen_ff};
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // Shared squarer: one coordinate difference squared per cycle.
   assign mul_srv = cnt_ff[2:1];
   assign mul_pt  = cnt_ff[0] ? py_ff : px_ff;
   always_comb begin
      case (mul_srv)
         2'd0:    mul_pos = cnt_ff[0] ? pos_y_ff[0] : pos_x_ff[0];
         2'd1:    mul_pos = cnt_ff[0] ? pos_y_ff[1] : pos_x_ff[1];
         2'd2:    mul_pos = cnt_ff[0] ? pos_y_ff[2] : pos_x_ff[2];
         default: mul_pos = '0;
      endcase
   end
   assign mul_diff = (mul_pos >= mul_pt) ? (mul_pos - mul_pt) : (mul_pt - mul_pos);
   assign mul_prod = PW'(mul_diff) * PW'(mul_diff);

   // Accumulation of the product registered one step earlier.
   assign prev     = cnt_ff - 3'd1;
   assign prev_srv = prev[2:1];
   assign dist_sum = acc_ff + D2W'(prod_ff);

   // One root bit per cycle, two radicand bits shifted in.
   assign rem_sh = {rem_ff[SQ_R-1:0], rad_ff[SQ_VW-1 -: 2]};
   assign trial  = {root_ff, 2'b01};

   // Saturating running total.
   assign tot_sum   = {1'b0, total_ff} + (TOTAL_W + 1)'(moved_ff);
   assign total_sat = tot_sum[TOTAL_W] ? '1 : tot_sum[TOTAL_W-1:0];

   // Next-state logic of the sequencer and datapath.
   always_comb begin
      state_in      = state_ff;
      cfg_in        = cfg_ff;
      pos_x_in      = pos_x_ff;
      pos_y_in      = pos_y_ff;
      total_in      = total_ff;
      cnt_in        = cnt_ff;
      px_in         = px_ff;
      py_in         = py_ff;
      prod_in       = prod_ff;
      acc_in        = acc_ff;
      best_d_in     = best_d_ff;
      best_in       = best_ff;
      rem_in        = rem_ff;
      root_in       = root_ff;
      rad_in        = rad_ff;
      sq_cnt_in     = sq_cnt_ff;
      moved_in      = moved_ff;
      restart_in    = restart_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_chosen_in = rsp_chosen_ff;
      rsp_moved_in  = rsp_moved_ff;
      rsp_total_in  = rsp_total_ff;

      // Register writes; unknown indexes are dropped.
      if (csr_valid && (csr_index < CSR_LIMIT)) begin
         cfg_in[csr_index] = csr_data;
      end

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (req_tuser) begin
                  for (int s = 0; s < NUM_SERVERS; s++) begin
                     pos_x_in[s] = CW'(cfg_ff[2 * s]);
                     pos_y_in[s] = CW'(cfg_ff[2 * s + 1]);
                  end
                  total_in   = '0;
                  moved_in   = '0;
                  restart_in = 1'b1;
                  state_in   = ST_EMIT;
               end else begin
                  px_in      = CW'(req_tdata[FIELD_W-1:0]);
                  py_in      = CW'(req_tdata[2*FIELD_W-1:FIELD_W]);
                  cnt_in     = '0;
                  restart_in = 1'b0;
                  state_in   = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            prod_in = mul_prod;
            cnt_in  = cnt_ff + 3'd1;
            if (cnt_ff != 3'd0) begin
               if (!prev[0]) begin
                  acc_in = D2W'(prod_ff);
               end else begin
                  // Server 0 wins ties with server 1; server 2 wins ties with the best.
                  case (prev_srv)
                     2'd0: begin
                        best_d_in = dist_sum;
                        best_in   = SERVER_0;
                     end
                     2'd1: begin
                        if (dist_sum < best_d_ff) begin
                           best_d_in = dist_sum;
                           best_in   = SERVER_1;
                        end
                     end
                     2'd2: begin
                        if (dist_sum <= best_d_ff) begin
                           best_d_in = dist_sum;
                           best_in   = SERVER_2;
                        end
                     end
                     default: ;
                  endcase
               end
            end
            if (cnt_ff == MUL_LAST) begin
               rad_in    = SQ_VW'(best_d_ff) << 16;
               rem_in    = '0;
               root_in   = '0;
               sq_cnt_in = SQ_CW'(SQ_R - 1);
               state_in  = ST_SQRT;
            end
         end
         ST_SQRT: begin
            if (rem_sh >= trial) begin
               rem_in  = rem_sh - trial;
               root_in = {root_ff[SQ_R-2:0], 1'b1};
            end else begin
               rem_in  = rem_sh;
               root_in = {root_ff[SQ_R-2:0], 1'b0};
            end
            rad_in = rad_ff << 2;
            if (sq_cnt_ff == '0) begin
               moved_in = MOVED_W'(root_in);
               state_in = ST_EMIT;
            end else begin
               sq_cnt_in = sq_cnt_ff - SQ_CW'(1);
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_moved_in = moved_ff;
               if (restart_ff) begin
                  rsp_chosen_in = CHOSEN_RESTART;
                  rsp_total_in  = '0;
               end else begin
                  rsp_chosen_in = best_ff;
                  rsp_total_in  = total_sat;
                  total_in      = total_sat;
                  case (best_ff)
                     SERVER_0: begin
                        pos_x_in[0] = px_ff;
                        pos_y_in[0] = py_ff;
                     end
                     SERVER_1: begin
                        pos_x_in[1] = px_ff;
                        pos_y_in[1] = py_ff;
                     end
                     default: begin
                        pos_x_in[2] = px_ff;
                        pos_y_in[2] = py_ff;
                     end
                  endcase
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control state and architectural state with reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         total_ff     <= '0;
         cfg_ff       <= CFG_RESET;
         for (int s = 0; s < NUM_SERVERS; s++) begin
            pos_x_ff[s] <= CW'(CFG_RESET[2 * s]);
            pos_y_ff[s] <= CW'(CFG_RESET[2 * s + 1]);
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         total_ff     <= total_in;
         cfg_ff       <= cfg_in;
         pos_x_ff     <= pos_x_in;
         pos_y_ff     <= pos_y_in;
      end
   end

   // Datapath registers without reset.
   always_ff @(posedge clock) begin
      cnt_ff        <= cnt_in;
      px_ff         <= px_in;
      py_ff         <= py_in;
      prod_ff       <= prod_in;
      acc_ff        <= acc_in;
      best_d_ff     <= best_d_in;
      best_ff       <= best_in;
      rem_ff        <= rem_in;
      root_ff       <= root_in;
      rad_ff        <= rad_in;
      sq_cnt_ff     <= sq_cnt_in;
      moved_ff      <= moved_in;
      restart_ff    <= restart_in;
      rsp_chosen_ff <= rsp_chosen_in;
      rsp_moved_ff  <= rsp_moved_in;
      rsp_total_ff  <= rsp_total_in;
   end

   // A restart clears the total in the cycle after it is taken.
   a_restart_clears: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser) |=> (total_ff == '0))
      else $error("total not cleared after restart");

   // Outside of restarts the running total never decreases.
   a_total_monotonic: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && out_free && !restart_ff) |=> (total_ff >= $past(total_ff)))
      else $error("running total decreased");

   // A restart acknowledgment carries zero distance and zero total.
   a_restart_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_chosen_ff == CHOSEN_RESTART) |->
      (rsp_moved_ff == '0 && rsp_total_ff == '0))
      else $error("restart result carries nonzero payload");

   // The square root only ever runs for a real server choice.
   a_sqrt_server: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SQRT) |-> (best_ff != CHOSEN_RESTART))
      else $error("square root started without a server choice");

endmodule

`default_nettype wire

### dv/tb_nearest_of_three_server_dispatch.sv
// Self-checking testbench for the nearest-of-three server dispatcher.
module tb_nearest_of_three_server_dispatch;
   timeunit 1ns;
   timeprecision 1ps;

   import nots_pkg::*;

   localparam int COORD_MAX       = (1 << FIELD_W) - 1;
   localparam int ITEMS_PER_PHASE = 125;
   localparam int PHASES          = 10;
   localparam int CALM_PHASE      = 8;
   localparam int SAT_MOVES       = 4110;
   localparam int HOLD_CYCLES     = 200;
   localparam int DIRECTED_COUNT  = 27;

   // Index that addresses none of the registers.
   localparam logic [CSR_IW-1:0] CSR_NONE = 3'd7;

   localparam logic [CSR_IW-1:0] START_REGS [CSR_COUNT] = '{
      CSR_START0_X, CSR_START0_Y, CSR_START1_X, CSR_START1_Y, CSR_START2_X, CSR_START2_Y};

   typedef struct packed {
      logic [CHOSEN_W-1:0] chosen;
      logic [MOVED_W-1:0]  moved;
      logic [TOTAL_W-1:0]  total;
   } dispatch_result_type;

   typedef enum logic [1:0] {ROW_REQUEST, ROW_RESTART, ROW_CSR} row_kind_type;

   // For register rows, a carries the write data.
   typedef struct packed {
      row_kind_type        kind;
      logic [CSR_IW-1:0]   idx;
      logic [FIELD_W-1:0]  a;
      logic [FIELD_W-1:0]  b;
      logic                typed;
      logic [CHOSEN_W-1:0] want_chosen;
      logic [MOVED_W-1:0]  want_moved;
      logic [TOTAL_W-1:0]  want_total;
   } stim_row_type;

   // Directed stimulus: reset placement first, then a placement built for ties.
   localparam stim_row_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      '{ROW_REQUEST, CSR_NONE, 12'd1,    12'd1,    1'b1, SERVER_0, 21'd0,     32'd0},
      '{ROW_REQUEST, CSR_NONE, 12'd1592, 12'd1,    1'b1, SERVER_1, 21'd0,     32'd0},
      '{ROW_REQUEST, CSR_NONE, 12'd787,  12'd936,  1'b1, SERVER_2, 21'd0,     32'd0},
      '{ROW_REQUEST, CSR_NONE, 12'd1,    12'd101,  1'b1, SERVER_0, 21'd25600, 32'd25600},
      '{ROW_REQUEST, CSR_NONE, 12'd1,    12'd1,    1'b1, SERVER_0, 21'd25600, 32'd51200},
      '{ROW_RESTART, CSR_NONE, 12'd4095, 12'd4095, 1'b1, CHOSEN_RESTART, 21'd0, 32'd0},
      '{ROW_REQUEST, CSR_NONE, 12'd0,    12'd0,    1'b0, SERVER_0, 21'd0,     32'd0},
      '{ROW_REQUEST, CSR_NONE, 12'd4095, 12'd4095, 1'b0, SERVER_0, 21'd0,     32'd0},
      '{ROW_REQUEST, CSR_NONE, 12'd4095, 12'd0,    1'b0, SERVER_0, 21'd0,     32'd0},
      '{ROW_REQUEST, CSR_NONE, 12'd0,    12'd4095, 1'b0, SERVER_0, 21'd0,     32'd0},
      '{ROW_CSR,     CSR_START0_X, 12'd0,    12'd0, 1'b0, SERVER_0, 21'd0, 32'd0},
      '{ROW_CSR,     CSR_START0_Y, 12'd0,    12'd0, 1'b0, SERVER_0, 21'd0, 32'd0},
      '{ROW_CSR,     CSR_START1_X, 12'd200,  12'd0, 1'b0, SERVER_0, 21'd0, 32'd0},
      '{ROW_CSR,     CSR_START1_Y, 12'd0,    12'd0, 1'b0, SERVER_0, 21'd0, 32'd0},
      '{ROW_CSR,     CSR_START2_X, 12'd100,  12'd0, 1'b0, SERVER_0, 21'd0, 32'd0},
      '{ROW_CSR,     CSR_START2_Y, 12'd200,  12'd0, 1'b0, SERVER_0, 21'd0, 32'd0},
      '{ROW_CSR,     CSR_LIMIT,    12'd4095, 12'd0, 1'b0, SERVER_0, 21'd0, 32'd0},
      '{ROW_CSR,     CSR_NONE,     12'd4095, 12'd0, 1'b0, SERVER_0, 21'd0, 32'd0},
      '{ROW_REQUEST, CSR_NONE, 12'd2048, 12'd2048, 1'b0, SERVER_0, 21'd0,     32'd0},
      '{ROW_RESTART, CSR_NONE, 12'd0,    12'd0,    1'b1, CHOSEN_RESTART, 21'd0, 32'd0},
      '{ROW_REQUEST, CSR_NONE, 12'd100,  12'd75,   1'b1, SERVER_2, 21'd32000, 32'd32000},
      '{ROW_RESTART, CSR_NONE, 12'd123,  12'd456,  1'b1, CHOSEN_RESTART, 21'd0, 32'd0},
      '{ROW_REQUEST, CSR_NONE, 12'd100,  12'd0,    1'b1, SERVER_0, 21'd25600, 32'd25600},
      '{ROW_RESTART, CSR_NONE, 12'd4095, 12'd0,    1'b1, CHOSEN_RESTART, 21'd0, 32'd0},
      '{ROW_REQUEST, CSR_NONE, 12'd200,  12'd125,  1'b1, SERVER_2, 21'd32000, 32'd32000},
      '{ROW_RESTART, CSR_NONE, 12'd0,    12'd4095, 1'b1, CHOSEN_RESTART, 21'd0, 32'd0},
      '{ROW_REQUEST, CSR_NONE, 12'd0,    12'd125,  1'b1, SERVER_2, 21'd32000, 32'd32000}
   };

   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [REQ_DW-1:0]   req_tdata  = '0;
   logic                req_tuser  = 1'b0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RSP_DW-1:0]   rsp_tdata;
   logic                csr_valid  = 1'b0;
   logic                csr_ready;
   logic [CSR_IW-1:0]   csr_index  = '0;
   logic [FIELD_W-1:0]  csr_data   = '0;

   // Predictor state: start registers, server positions and the distance total.
   logic [FIELD_W-1:0]  start_reg [CSR_COUNT];
   logic [FIELD_W-1:0]  srv_x [NUM_SERVERS];
   logic [FIELD_W-1:0]  srv_y [NUM_SERVERS];
   logic [TOTAL_W-1:0]  travel_sum;

   dispatch_result_type pending_results [$];
   int                  fail_count = 0;
   int                  rsp_count  = 0;
   int                  hold_asked = 0;
   logic                idle_on    = 1'b1;

   nearest_of_three_server_dispatch uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      #5_000_000;
      $display("Regression FAIL");
      $finish;
   end

   // Bitwise integer square root, one result bit per pass.
   function automatic longint unsigned root_floor(longint unsigned v);
      longint unsigned rem;
      longint unsigned res;
      longint unsigned probe;
      rem = v;
      res = 0;
      probe = 64'd1 << 62;
      while (probe != 0) begin
         if (rem >= res + probe) begin
            rem -= res + probe;
            res = (res >> 1) + probe;
         end else begin
            res >>= 1;
         end
         probe >>= 2;
      end
      return res;
   endfunction

   // Works out the response to one request and moves the chosen server.
   function automatic dispatch_result_type dispatch_predict(logic restart,
                                                            logic [FIELD_W-1:0] px,
                                                            logic [FIELD_W-1:0] py);
      dispatch_result_type r;
      longint unsigned     sq_d [NUM_SERVERS];
      longint unsigned     best_d;
      longint unsigned     step;
      longint unsigned     sum;
      int                  best;
      int                  dx;
      int                  dy;
      if (restart) begin
         for (int s = 0; s < NUM_SERVERS; s++) begin
            srv_x[s] = start_reg[2 * s];
            srv_y[s] = start_reg[2 * s + 1];
         end
         travel_sum = '0;
         r.chosen = CHOSEN_RESTART;
         r.moved  = '0;
         r.total  = '0;
         return r;
      end
      for (int s = 0; s < NUM_SERVERS; s++) begin
         dx = int'(srv_x[s]) - int'(px);
         dy = int'(srv_y[s]) - int'(py);
         sq_d[s] = longint'(dx * dx + dy * dy);
      end
      // Server 0 wins a tie with server 1; server 2 wins any tie with the best so far.
      best = (sq_d[0] <= sq_d[1]) ? 0 : 1;
      best_d = sq_d[best];
      if (sq_d[2] <= best_d) begin
         best = 2;
         best_d = sq_d[2];
      end
      step = root_floor(best_d << 16);
      srv_x[best] = px;
      srv_y[best] = py;
      sum = 64'(travel_sum) + step;
      travel_sum = (sum > 64'hFFFF_FFFF) ? '1 : sum[TOTAL_W-1:0];
      r.chosen = (best == 0) ? SERVER_0 : (best == 1) ? SERVER_1 : SERVER_2;
      r.moved  = step[MOVED_W-1:0];
      r.total  = travel_sum;
      return r;
   endfunction

   function automatic void note_failure(string msg);
      fail_count++;
      if (fail_count <= 10)
         $display("ERROR: %s", msg);
   endfunction

   // Random coordinate within a few pixels of c, clamped to the plane.
   function automatic logic [FIELD_W-1:0] nudge(logic [FIELD_W-1:0] c);
      int t;
      t = int'(c) + int'($urandom_range(0, 16)) - 8;
      if (t < 0)
         t = 0;
      if (t > COORD_MAX)
         t = COORD_MAX;
      return t[FIELD_W-1:0];
   endfunction

   // Offers one request, after an optional gap, and returns at its acceptance edge.
   task automatic offer_item(logic restart, logic [FIELD_W-1:0] px, logic [FIELD_W-1:0] py);
      int gap;
      if (idle_on && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 7);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {py, px};
      req_tuser  <= restart;
      do @(posedge clock); while (req_tready !== 1'b1);
   endtask

   task automatic send_checked(logic restart, logic [FIELD_W-1:0] px, logic [FIELD_W-1:0] py);
      offer_item(restart, px, py);
      pending_results.push_back(dispatch_predict(restart, px, py));
   endtask

   // Leaves valid high; the caller lowers it after the last write of a batch.
   task automatic write_csr(logic [CSR_IW-1:0] idx, logic [FIELD_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (csr_ready !== 1'b1);
      if (idx < CSR_COUNT)
         start_reg[idx] = val;
   endtask

   // Stops offering and waits until every expected response has come back.
   task automatic drain();
      req_tvalid <= 1'b0;
      csr_valid  <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
      repeat (2) @(posedge clock);
   endtask

   // Response side: checks each accepted response and stalls at random.
   initial begin
      dispatch_result_type want;
      int stall_left;
      int hold_left;
      int holds_seen;
      stall_left = 0;
      hold_left  = 0;
      holds_seen = 0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
            rsp_count++;
            if (pending_results.size() == 0) begin
               note_failure($sformatf("response %0d arrived with nothing pending: %h",
                                      rsp_count, rsp_tdata));
            end else begin
               want = pending_results.pop_front();
               if (rsp_tdata[1:0] !== want.chosen || rsp_tdata[22:2] !== want.moved ||
                   rsp_tdata[54:23] !== want.total || rsp_tdata[55] !== 1'b0) begin
                  note_failure($sformatf(
                     "response %0d: chosen %0d moved %0d total %0d pad %b, expected %0d %0d %0d",
                     rsp_count, rsp_tdata[1:0], rsp_tdata[22:2], rsp_tdata[54:23],
                     rsp_tdata[55], want.chosen, want.moved, want.total));
               end
            end
         end
         if (holds_seen != hold_asked) begin
            holds_seen++;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 7) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Request side: directed table, random phases and a run up to total saturation.
   initial begin
      stim_row_type        row;
      dispatch_result_type pred;
      logic [FIELD_W-1:0]  px;
      logic [FIELD_W-1:0]  py;
      logic [FIELD_W-1:0]  cx;
      logic [FIELD_W-1:0]  cy;
      logic [FIELD_W-1:0]  same;
      logic                restart;
      logic                taken;
      int                  sel;
      int                  s;

      for (int i = 0; i < CSR_COUNT; i++)
         start_reg[i] = CFG_RESET[i];
      void'(dispatch_predict(1'b1, '0, '0));

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_COUNT; i++) begin
         row = DIRECTED_ROWS[i];
         if (row.kind == ROW_CSR) begin
            drain();
            write_csr(row.idx, row.a);
         end else begin
            csr_valid <= 1'b0;
            offer_item(row.kind == ROW_RESTART, row.a, row.b);
            pred = dispatch_predict(row.kind == ROW_RESTART, row.a, row.b);
            if (row.typed) begin
               pred.chosen = row.want_chosen;
               pred.moved  = row.want_moved;
               pred.total  = row.want_total;
            end
            pending_results.push_back(pred);
         end
      end

      for (int ph = 0; ph < PHASES; ph++) begin
         idle_on <= (ph < CALM_PHASE) && (ph % 4 != 3);

         // Three servers on three corners; each request lands on the free corner,
         // so every move is a full side and the total runs into saturation.
         if (ph == CALM_PHASE) begin
            drain();
            write_csr(CSR_START0_X, 12'd0);
            write_csr(CSR_START0_Y, 12'd0);
            write_csr(CSR_START1_X, FIELD_W'(COORD_MAX));
            write_csr(CSR_START1_Y, 12'd0);
            write_csr(CSR_START2_X, FIELD_W'(COORD_MAX));
            write_csr(CSR_START2_Y, FIELD_W'(COORD_MAX));
            csr_valid <= 1'b0;
            send_checked(1'b1, '0, '0);
            for (int n = 0; n < SAT_MOVES; n++) begin
               cx = '0;
               cy = '0;
               for (int c = 0; c < 4; c++) begin
                  px = (c == 1 || c == 2) ? FIELD_W'(COORD_MAX) : '0;
                  py = (c >= 2) ? FIELD_W'(COORD_MAX) : '0;
                  taken = 1'b0;
                  for (int k = 0; k < NUM_SERVERS; k++)
                     if (srv_x[k] == px && srv_y[k] == py)
                        taken = 1'b1;
                  if (!taken) begin
                     cx = px;
                     cy = py;
                  end
               end
               send_checked(1'b0, cx, cy);
            end
            send_checked(1'b1, FIELD_W'(COORD_MAX), FIELD_W'(COORD_MAX));
            send_checked(1'b0, FIELD_W'(COORD_MAX), 12'd0);
         end

         // New start placement for this phase: all zero, all maximum, one shared
         // point, or random.
         drain();
         same = FIELD_W'($urandom_range(0, COORD_MAX));
         for (int r = 0; r < CSR_COUNT; r++) begin
            if (ph == 0)
               px = '0;
            else if (ph == 1)
               px = FIELD_W'(COORD_MAX);
            else if (ph == 2)
               px = same;
            else
               px = FIELD_W'($urandom_range(0, COORD_MAX));
            write_csr(START_REGS[r], px);
         end
         if ($urandom_range(0, 1) == 1)
            write_csr(($urandom_range(0, 1) == 1) ? CSR_LIMIT : CSR_NONE,
                      FIELD_W'($urandom_range(0, COORD_MAX)));
         csr_valid <= 1'b0;
         send_checked(1'b1, FIELD_W'($urandom_range(0, COORD_MAX)),
                      FIELD_W'($urandom_range(0, COORD_MAX)));

         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            // Long response stall while requests keep coming.
            if (ph == 3 && n == 20)
               hold_asked <= hold_asked + 1;
            // Pause the request side until everything is back.
            if (ph == 5 && n == 60)
               drain();

            sel = $urandom_range(0, 99);
            s = $urandom_range(0, NUM_SERVERS - 1);
            restart = 1'b0;
            px = FIELD_W'($urandom_range(0, COORD_MAX));
            py = FIELD_W'($urandom_range(0, COORD_MAX));
            if (ph == 0 && n == 0) begin
               px = FIELD_W'(COORD_MAX);
               py = FIELD_W'(COORD_MAX);
            end else if (sel < 4) begin
               restart = 1'b1;
            end else if (sel < 20) begin
               px = ($urandom_range(0, 1) == 1) ? FIELD_W'(COORD_MAX) : '0;
               py = ($urandom_range(0, 1) == 1) ? FIELD_W'(COORD_MAX) : '0;
            end else if (sel < 30) begin
               px = srv_x[s];
               py = srv_y[s];
            end else if (sel < 50) begin
               px = nudge(srv_x[s]);
               py = nudge(srv_y[s]);
            end
            send_checked(restart, px, py);
         end
      end

      drain();
      repeat (64) @(posedge clock);
      if (fail_count == 0 && pending_results.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

### files.f
hw/rtl/nots_pkg.sv
hw/rtl/nearest_of_three_server_dispatch.sv
dv/tb_nearest_of_three_server_dispatch.sv
